[rtl/core/i2c_register_transfer_sequencer_unit_macros.svh]
// Assertion helpers for the register transfer sequencer
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define I2CRTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2crts: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define I2CRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2crts: next-cycle check failed");

`endif

[rtl/core/i2crts_pkg.sv]
package i2crts_pkg;

    // Status codes after masking
    localparam logic [7:0] STATUS_MASK    = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RSTART      = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
    // Marks a phase that awaits no status
    localparam logic [8:0] ST_NONE        = 9'h100;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam int ITEM_DATA_W = 56;
    localparam int RES_DATA_W  = 40;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_ADDR_W  = 4'd2,
        PH_REG     = 4'd3,
        PH_RSTART  = 4'd4,
        PH_ADDR_R  = 4'd5,
        PH_RX_ACK  = 4'd6,
        PH_RX_NACK = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_TX_DATA = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        CMD_BEGIN_READ  = 3'd0,
        CMD_BEGIN_WRITE = 3'd1,
        CMD_STATUS      = 3'd2,
        CMD_TICK        = 3'd3,
        CMD_WRITE_DATA  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_TX      = 3'd2,
        ACT_RX_ACK  = 3'd3,
        ACT_RX_NACK = 3'd4,
        ACT_STOP    = 3'd5
    } t_act;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  device_address;
        logic [7:0]  register_index;
        logic [15:0] transfer_length;
        logic [7:0]  status_code;
        logic [7:0]  received_byte;
        logic [7:0]  write_byte;
    } t_item;

    typedef struct packed {
        t_act        bus_action;
        logic [7:0]  transmit_byte;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [15:0] read_index;
        logic        data_request;
        logic        done_res;
        logic        error;
        logic        last;
    } t_result;

    // Status code awaited in a phase
    function automatic logic [8:0] expected_code(input t_phase ph);
        logic [8:0] code;
        case (ph)
            PH_START:   code = {1'b0, ST_START};
            PH_ADDR_W:  code = {1'b0, ST_ADDR_W_ACK};
            PH_REG:     code = {1'b0, ST_DATA_W_ACK};
            PH_RSTART:  code = {1'b0, ST_RSTART};
            PH_ADDR_R:  code = {1'b0, ST_ADDR_R_ACK};
            PH_RX_ACK:  code = {1'b0, ST_DATA_R_ACK};
            PH_RX_NACK: code = {1'b0, ST_DATA_R_NACK};
            PH_TX_DATA: code = {1'b0, ST_DATA_W_ACK};
            default:    code = ST_NONE;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/i2c_register_transfer_sequencer_unit.sv]
// I2C master register transfer sequencer, sitting above a byte-level bus engine.
// Slave stream: tuser carries the command (begin read, begin write, status event,
// tick, write data byte); tdata carries the operands. Each command word yields at
// most one result word on the master stream: a bus action for the engine, plus
// read data, a payload request or a done/timeout flag; tlast is set on every word.
// Config channel: one 16-bit timeout limit, always ready; write it while idle.
// Path: a word is held in the input register and is evaluated against the
// sequence state as it leaves it; its result is loaded into the output register
// as the phase updates, so m_axis_tvalid rises once the word has passed both registers.
// Throughput: one command word per cycle while the output register is free,
// with the phase update between the input and output registers. Words that
// cause no result are consumed without touching the output register.
// Reset (synchronous, active low) empties both registers, returns the sequence
// to idle and loads the timeout limit with 1000 ticks.
// When the master side stalls, the output register holds its word; the input
// register still takes one more word, then tready drops until the output frees.
module i2c_register_transfer_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // device_address[6:0], register_index[14:7], transfer_length[30:15],
    // status_code[38:31], received_byte[46:39], write_byte[54:47], zero[55]
    input  logic [i2crts_pkg::ITEM_DATA_W-1:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // transmit_byte[7:0], read_valid[8], read_byte[16:9], read_index[32:17],
    // data_request[33], done_res[34], error[35], zero[39:36]
    output logic [i2crts_pkg::RES_DATA_W-1:0] m_axis_tdata,
    // bus_action[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Timeout limit write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import i2crts_pkg::*;

    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_out_free;
    logic    w_fire;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;
    logic    w_out_done;
    logic    w_out_err;
    logic    w_out_read;
    logic    w_out_stop;
    logic    w_out_rx_stop;
    logic    w_out_stall;

    // Unpack the command word
    always_comb begin
        w_in_item.command         = s_axis_tuser;
        w_in_item.device_address  = s_axis_tdata[6:0];
        w_in_item.register_index  = s_axis_tdata[14:7];
        w_in_item.transfer_length = s_axis_tdata[30:15];
        w_in_item.status_code     = s_axis_tdata[38:31];
        w_in_item.received_byte   = s_axis_tdata[46:39];
        w_in_item.write_byte      = s_axis_tdata[54:47];
    end

    i2crts_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_fire),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    // Evaluate the held word only when its result has somewhere to go
    assign w_fire = w_held_valid && w_out_free;

    i2crts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_item      (w_held_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    i2crts_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out_res)
    );

    // Pack the result word
    assign m_axis_tuser = w_out_res.bus_action;
    assign m_axis_tlast = w_out_res.last;
    assign m_axis_tdata = {4'b0000,
                           w_out_res.error,
                           w_out_res.done_res,
                           w_out_res.data_request,
                           w_out_res.read_index,
                           w_out_res.read_byte,
                           w_out_res.read_valid,
                           w_out_res.transmit_byte};

    assign o_cfg_ready = 1'b1;

    // Conditions watched on the result side
    assign w_out_done    = m_axis_tvalid && w_out_res.done_res;
    assign w_out_err     = m_axis_tvalid && w_out_res.error;
    assign w_out_read    = m_axis_tvalid && w_out_res.read_valid;
    assign w_out_stop    = (w_out_res.bus_action == ACT_STOP);
    assign w_out_rx_stop = w_out_res.bus_action inside {ACT_RX_ACK, ACT_RX_NACK, ACT_STOP};
    assign w_out_stall   = m_axis_tvalid && !m_axis_tready && w_held_valid;

`include "i2c_register_transfer_sequencer_unit_macros.svh"

    // A finished transfer always releases the bus
    `I2CRTS_ASSERT_NOW(a_done_stops, i_clk, i_rst_n, w_out_done, w_out_stop)

    // An error is only ever reported together with done
    `I2CRTS_ASSERT_NOW(a_error_done, i_clk, i_rst_n, w_out_err, w_out_res.done_res)

    // Received data only travels with a receive or stop action
    `I2CRTS_ASSERT_NOW(a_read_action, i_clk, i_rst_n, w_out_read, w_out_rx_stop)

    // A stalled result with a held word backs up the command stream
    `I2CRTS_ASSERT_NOW(a_backpressure, i_clk, i_rst_n, w_out_stall, !s_axis_tready)

endmodule

[rtl/core/i2crts_in_stage.sv]
module i2crts_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2crts_pkg::t_item   i_item,
    input  logic                i_take,
    output logic                o_valid,
    output i2crts_pkg::t_item   o_item
);
    import i2crts_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // Accept a word when empty or when the held one is consumed this cycle
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload until the next word arrives
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/i2crts_core.sv]
module i2crts_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_fire,
    input  i2crts_pkg::t_item   i_item,
    output logic                o_res_valid,
    output i2crts_pkg::t_result o_res
);
    import i2crts_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_is_read, n_is_read;
    logic [6:0]  r_addr, n_addr;
    logic [7:0]  r_reg, n_reg;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_wait, n_wait;
    logic [15:0] r_timeout;

    t_cmd        w_cmd;
    logic        w_match;
    logic        w_waiting;
    logic        w_timeout;
    logic [15:0] w_wait_inc;
    logic [15:0] w_rem_dec;
    logic [15:0] w_begin_len;

    // Shared decode
    assign w_cmd      = t_cmd'(i_item.command);
    assign w_match    = (w_cmd == CMD_STATUS) &&
                        ({1'b0, i_item.status_code & STATUS_MASK} == expected_code(r_phase));
    assign w_waiting  = (r_phase != PH_IDLE) && (r_phase != PH_PAYLOAD);
    assign w_wait_inc = r_wait + 16'd1;
    assign w_timeout  = (w_wait_inc >= r_timeout);
    assign w_rem_dec  = r_rem - 16'd1;
    assign w_begin_len = ((w_cmd == CMD_BEGIN_READ) && (i_item.transfer_length == 16'd0))
                       ? 16'd1 : i_item.transfer_length;

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_addr    = r_addr;
        n_reg     = r_reg;
        n_rem     = r_rem;
        n_pos     = r_pos;
        n_wait    = r_wait;
        if (i_fire) begin
            case (w_cmd)
                CMD_BEGIN_READ, CMD_BEGIN_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_read = (w_cmd == CMD_BEGIN_READ);
                        n_addr    = i_item.device_address;
                        n_reg     = i_item.register_index;
                        n_rem     = w_begin_len;
                        n_pos     = 16'd0;
                        n_phase   = PH_START;
                        n_wait    = 16'd0;
                    end
                end
                CMD_STATUS: begin
                    if (w_match) begin
                        n_wait = 16'd0;
                        case (r_phase)
                            PH_START:  n_phase = PH_ADDR_W;
                            PH_ADDR_W: n_phase = PH_REG;
                            PH_REG: begin
                                if (r_is_read) begin
                                    n_phase = PH_RSTART;
                                end else begin
                                    n_phase = (r_rem == 16'd0) ? PH_IDLE : PH_PAYLOAD;
                                end
                            end
                            PH_RSTART: n_phase = PH_ADDR_R;
                            PH_ADDR_R: n_phase = (r_rem > 16'd1) ? PH_RX_ACK : PH_RX_NACK;
                            PH_RX_ACK: begin
                                n_pos   = r_pos + 16'd1;
                                n_rem   = w_rem_dec;
                                n_phase = (w_rem_dec > 16'd1) ? PH_RX_ACK : PH_RX_NACK;
                            end
                            PH_RX_NACK: n_phase = PH_IDLE;
                            PH_TX_DATA: begin
                                n_rem   = w_rem_dec;
                                n_phase = (w_rem_dec == 16'd0) ? PH_IDLE : PH_PAYLOAD;
                            end
                            default: n_phase = r_phase;
                        endcase
                    end
                end
                CMD_TICK: begin
                    if (w_waiting) begin
                        if (w_timeout) begin
                            n_phase = PH_IDLE;
                            n_wait  = 16'd0;
                        end else begin
                            n_wait = w_wait_inc;
                        end
                    end
                end
                CMD_WRITE_DATA: begin
                    if (r_phase == PH_PAYLOAD) begin
                        n_phase = PH_TX_DATA;
                        n_wait  = 16'd0;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Result word
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;
        case (w_cmd)
            CMD_BEGIN_READ, CMD_BEGIN_WRITE: begin
                if (r_phase == PH_IDLE) begin
                    o_res_valid      = 1'b1;
                    o_res.bus_action = ACT_START;
                end
            end
            CMD_STATUS: begin
                if (w_match) begin
                    o_res_valid = 1'b1;
                    case (r_phase)
                        PH_START: begin
                            o_res.bus_action    = ACT_TX;
                            o_res.transmit_byte = {r_addr, 1'b0};
                        end
                        PH_ADDR_W: begin
                            o_res.bus_action    = ACT_TX;
                            o_res.transmit_byte = r_reg;
                        end
                        PH_REG: begin
                            if (r_is_read) begin
                                o_res.bus_action = ACT_START;
                            end else if (r_rem == 16'd0) begin
                                o_res.bus_action = ACT_STOP;
                                o_res.done_res   = 1'b1;
                            end else begin
                                o_res.data_request = 1'b1;
                            end
                        end
                        PH_RSTART: begin
                            o_res.bus_action    = ACT_TX;
                            o_res.transmit_byte = {r_addr, 1'b1};
                        end
                        PH_ADDR_R: begin
                            o_res.bus_action = (r_rem > 16'd1) ? ACT_RX_ACK : ACT_RX_NACK;
                        end
                        PH_RX_ACK: begin
                            o_res.bus_action = (w_rem_dec > 16'd1) ? ACT_RX_ACK : ACT_RX_NACK;
                            o_res.read_valid = 1'b1;
                            o_res.read_byte  = i_item.received_byte;
                            o_res.read_index = r_pos;
                        end
                        PH_RX_NACK: begin
                            o_res.bus_action = ACT_STOP;
                            o_res.read_valid = 1'b1;
                            o_res.read_byte  = i_item.received_byte;
                            o_res.read_index = r_pos;
                            o_res.done_res   = 1'b1;
                        end
                        PH_TX_DATA: begin
                            if (w_rem_dec == 16'd0) begin
                                o_res.bus_action = ACT_STOP;
                                o_res.done_res   = 1'b1;
                            end else begin
                                o_res.data_request = 1'b1;
                            end
                        end
                        default: o_res_valid = 1'b0;
                    endcase
                end
            end
            CMD_TICK: begin
                if (w_waiting && w_timeout) begin
                    o_res_valid      = 1'b1;
                    o_res.bus_action = ACT_STOP;
                    o_res.done_res   = 1'b1;
                    o_res.error      = 1'b1;
                end
            end
            CMD_WRITE_DATA: begin
                if (r_phase == PH_PAYLOAD) begin
                    o_res_valid         = 1'b1;
                    o_res.bus_action    = ACT_TX;
                    o_res.transmit_byte = i_item.write_byte;
                end
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    // Advance sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_read <= 1'b0;
            r_addr    <= '0;
            r_reg     <= '0;
            r_rem     <= '0;
            r_pos     <= '0;
            r_wait    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_is_read <= n_is_read;
            r_addr    <= n_addr;
            r_reg     <= n_reg;
            r_rem     <= n_rem;
            r_pos     <= n_pos;
            r_wait    <= n_wait;
        end
    end

    // Timeout limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

endmodule

[rtl/core/i2crts_out_stage.sv]
module i2crts_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2crts_pkg::t_result i_res,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output i2crts_pkg::t_result o_res
);
    import i2crts_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Slot frees when empty or when the held word leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[tb/tb_i2c_register_transfer_sequencer_unit.sv]
`timescale 1ns / 1ps

module tb_i2c_register_transfer_sequencer_unit;
    import i2crts_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [ITEM_DATA_W-1:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [RES_DATA_W-1:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    i2c_register_transfer_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sequencer state as the predictor sees it
    t_phase      seq_phase = PH_IDLE;
    logic        seq_is_read = 1'b0;
    logic [6:0]  seq_addr = '0;
    logic [7:0]  seq_reg = '0;
    logic [15:0] seq_left = '0;
    logic [15:0] seq_pos = '0;
    logic [15:0] seq_ticks = '0;
    logic [15:0] limit_now = TIMEOUT_RESET;

    // Traffic between the processes
    t_item   command_words[$];
    t_result bus_steps_due[$];
    t_item   word_on_bus = '0;

    int  words_issued = 0;
    int  words_taken = 0;
    int  words_planned = 0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  transfers_begun = 0;
    int  timeouts_seen = 0;
    int  quiet_cycles = 0;
    int  gen_limit = int'(TIMEOUT_RESET);
    int  noise_pct = 0;
    bit  sender_idles = 1'b0;
    bit  receiver_stalls = 1'b0;
    bit  long_stall_armed = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void enter_phase(input t_phase p);
        seq_phase = p;
        seq_ticks = '0;
    endfunction

    // Either ask for the next payload word or close the write
    function automatic void after_write_header(inout t_result r);
        if (seq_left == 16'd0) begin
            enter_phase(PH_IDLE);
            r.bus_action = ACT_STOP;
            r.done_res = 1'b1;
        end else begin
            enter_phase(PH_PAYLOAD);
            r.bus_action = ACT_NONE;
            r.data_request = 1'b1;
        end
    endfunction

    // Apply one command word; return 1 with the bus step it causes
    function automatic bit advance_sequence(input t_item w, output t_result r);
        logic [8:0] awaited;
        r = '0;
        r.last = 1'b1;
        r.bus_action = ACT_NONE;
        case (w.command)
            CMD_BEGIN_READ, CMD_BEGIN_WRITE: begin
                if (seq_phase != PH_IDLE)
                    return 1'b0;
                seq_is_read = (w.command == CMD_BEGIN_READ);
                seq_addr = w.device_address;
                seq_reg = w.register_index;
                seq_left = w.transfer_length;
                if (seq_is_read && seq_left == 16'd0)
                    seq_left = 16'd1;
                seq_pos = '0;
                enter_phase(PH_START);
                transfers_begun++;
                r.bus_action = ACT_START;
                return 1'b1;
            end
            CMD_STATUS: begin
                case (seq_phase)
                    PH_START:   awaited = {1'b0, ST_START};
                    PH_ADDR_W:  awaited = {1'b0, ST_ADDR_W_ACK};
                    PH_REG:     awaited = {1'b0, ST_DATA_W_ACK};
                    PH_RSTART:  awaited = {1'b0, ST_RSTART};
                    PH_ADDR_R:  awaited = {1'b0, ST_ADDR_R_ACK};
                    PH_RX_ACK:  awaited = {1'b0, ST_DATA_R_ACK};
                    PH_RX_NACK: awaited = {1'b0, ST_DATA_R_NACK};
                    PH_TX_DATA: awaited = {1'b0, ST_DATA_W_ACK};
                    default:    awaited = 9'h100;
                endcase
                if ({1'b0, w.status_code & STATUS_MASK} != awaited)
                    return 1'b0;
                case (seq_phase)
                    PH_START: begin
                        enter_phase(PH_ADDR_W);
                        r.bus_action = ACT_TX;
                        r.transmit_byte = {seq_addr, 1'b0};
                    end
                    PH_ADDR_W: begin
                        enter_phase(PH_REG);
                        r.bus_action = ACT_TX;
                        r.transmit_byte = seq_reg;
                    end
                    PH_REG: begin
                        if (seq_is_read) begin
                            enter_phase(PH_RSTART);
                            r.bus_action = ACT_START;
                        end else begin
                            after_write_header(r);
                        end
                    end
                    PH_RSTART: begin
                        enter_phase(PH_ADDR_R);
                        r.bus_action = ACT_TX;
                        r.transmit_byte = {seq_addr, 1'b1};
                    end
                    PH_ADDR_R: begin
                        enter_phase(seq_left > 16'd1 ? PH_RX_ACK : PH_RX_NACK);
                        r.bus_action = seq_left > 16'd1 ? ACT_RX_ACK : ACT_RX_NACK;
                    end
                    PH_RX_ACK: begin
                        r.read_valid = 1'b1;
                        r.read_byte = w.received_byte;
                        r.read_index = seq_pos;
                        seq_pos = seq_pos + 16'd1;
                        seq_left = seq_left - 16'd1;
                        enter_phase(seq_left > 16'd1 ? PH_RX_ACK : PH_RX_NACK);
                        r.bus_action = seq_left > 16'd1 ? ACT_RX_ACK : ACT_RX_NACK;
                    end
                    PH_RX_NACK: begin
                        r.read_valid = 1'b1;
                        r.read_byte = w.received_byte;
                        r.read_index = seq_pos;
                        enter_phase(PH_IDLE);
                        r.bus_action = ACT_STOP;
                        r.done_res = 1'b1;
                    end
                    default: begin
                        // Payload byte acknowledged
                        seq_left = seq_left - 16'd1;
                        after_write_header(r);
                    end
                endcase
                return 1'b1;
            end
            CMD_TICK: begin
                if (seq_phase == PH_IDLE || seq_phase == PH_PAYLOAD)
                    return 1'b0;
                seq_ticks = seq_ticks + 16'd1;
                if (seq_ticks < limit_now)
                    return 1'b0;
                enter_phase(PH_IDLE);
                timeouts_seen++;
                r.bus_action = ACT_STOP;
                r.done_res = 1'b1;
                r.error = 1'b1;
                return 1'b1;
            end
            CMD_WRITE_DATA: begin
                if (seq_phase != PH_PAYLOAD)
                    return 1'b0;
                enter_phase(PH_TX_DATA);
                r.bus_action = ACT_TX;
                r.transmit_byte = w.write_byte;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Word planning
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    function automatic t_item random_word();
        t_item w;
        w.command = 3'($urandom_range(0, 7));
        w.device_address = 7'($urandom_range(0, 127));
        w.register_index = 8'($urandom_range(0, 255));
        w.transfer_length = 16'($urandom_range(0, 65535));
        w.status_code = 8'($urandom_range(0, 255));
        w.received_byte = 8'($urandom_range(0, 255));
        w.write_byte = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic queue_word(input t_item w, input bit counts);
        command_words.push_back(w);
        words_issued++;
        if (counts)
            words_planned++;
    endtask

    task automatic queue_ticks(input int n);
        t_item w;
        repeat (n) begin
            w = random_word();
            w.command = CMD_TICK;
            queue_word(w, 1'b0);
        end
    endtask

    task automatic queue_status(input logic [7:0] code);
        t_item w;
        w = random_word();
        w.command = CMD_STATUS;
        w.status_code = code | 8'($urandom_range(0, 7));
        queue_word(w, 1'b1);
    endtask

    task automatic queue_begin(input bit rd, input logic [6:0] a, input logic [7:0] rg,
                               input logic [15:0] len);
        t_item w;
        w = random_word();
        w.command = rd ? CMD_BEGIN_READ : CMD_BEGIN_WRITE;
        w.device_address = a;
        w.register_index = rg;
        w.transfer_length = len;
        queue_word(w, 1'b1);
    endtask

    // Words that the sequencer should drop mid-transfer; zero awaited means payload wait
    task automatic queue_noise(input logic [7:0] awaited);
        t_item w;
        int cap;
        if ($urandom_range(0, 99) >= noise_pct)
            return;
        w = random_word();
        case ($urandom_range(0, 4))
            0: begin
                cap = (gen_limit - 1 < 3) ? gen_limit - 1 : 3;
                queue_ticks(awaited == 8'h00 ? $urandom_range(1, 3) : $urandom_range(0, cap));
                return;
            end
            1: begin
                w.command = CMD_STATUS;
                while (awaited != 8'h00 && (w.status_code & STATUS_MASK) == awaited)
                    w.status_code = 8'($urandom_range(0, 255));
            end
            2: w.command = (awaited != 8'h00) ? CMD_WRITE_DATA : CMD_TICK;
            3: w.command = $urandom_range(0, 1) ? CMD_BEGIN_READ : CMD_BEGIN_WRITE;
            default: w.command = CMD_WRITE_DATA + 3'($urandom_range(1, 3));
        endcase
        queue_word(w, 1'b0);
    endtask

    // Words that the sequencer should drop while idle
    task automatic queue_idle_noise(input int kind);
        t_item w;
        w = random_word();
        case (kind)
            0: w.command = CMD_TICK;
            1: w.command = CMD_STATUS;
            2: w.command = CMD_WRITE_DATA;
            default: w.command = CMD_WRITE_DATA + 3'($urandom_range(1, 3));
        endcase
        queue_word(w, 1'b0);
    endtask

    // Full read; abort_at picks the status step replaced by a timeout
    task automatic queue_read(input logic [6:0] a, input logic [7:0] rg,
                              input logic [15:0] len, input int abort_at);
        int steps;
        logic [7:0] awaited;
        steps = 5 + ((len == 16'd0) ? 1 : int'(len));
        queue_begin(1'b1, a, rg, len);
        for (int step = 0; step < steps; step++) begin
            if (step == abort_at) begin
                queue_ticks(gen_limit);
                return;
            end
            if (step == 0)
                awaited = ST_START;
            else if (step == 1)
                awaited = ST_ADDR_W_ACK;
            else if (step == 2)
                awaited = ST_DATA_W_ACK;
            else if (step == 3)
                awaited = ST_RSTART;
            else if (step == 4)
                awaited = ST_ADDR_R_ACK;
            else if (step == steps - 1)
                awaited = ST_DATA_R_NACK;
            else
                awaited = ST_DATA_R_ACK;
            queue_noise(awaited);
            queue_status(awaited);
        end
    endtask

    // Full write; an abort inside the payload lands after the data word
    task automatic queue_write(input logic [6:0] a, input logic [7:0] rg,
                               input logic [15:0] len, input int abort_at);
        t_item w;
        logic [7:0] awaited;
        queue_begin(1'b0, a, rg, len);
        for (int step = 0; step < 3 + int'(len); step++) begin
            if (step >= 3) begin
                queue_noise(8'h00);
                w = random_word();
                w.command = CMD_WRITE_DATA;
                queue_word(w, 1'b1);
            end
            if (step == abort_at) begin
                queue_ticks(gen_limit);
                return;
            end
            if (step == 0)
                awaited = ST_START;
            else if (step == 1)
                awaited = ST_ADDR_W_ACK;
            else
                awaited = ST_DATA_W_ACK;
            queue_noise(awaited);
            queue_status(awaited);
        end
    endtask

    task automatic queue_random_transfer();
        int r;
        int steps;
        int abort_at;
        bit rd;
        logic [15:0] len;
        rd = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 50)
            len = 16'($urandom_range(0, 3));
        else if (r < 85)
            len = 16'($urandom_range(4, 12));
        else if (r < 95 || gen_limit > 64)
            len = 16'($urandom_range(13, 40));
        else
            len = 16'($urandom_range(0, 65535));
        steps = rd ? 5 + ((len == 16'd0) ? 1 : int'(len)) : 3 + int'(len);
        abort_at = -1;
        // Huge lengths only ever run until a timeout
        if (gen_limit <= 64 && (r >= 95 || $urandom_range(0, 99) < 20))
            abort_at = $urandom_range(0, (steps > 12 ? 12 : steps) - 1);
        if (rd)
            queue_read(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), len, abort_at);
        else
            queue_write(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), len, abort_at);
        if ($urandom_range(0, 99) < noise_pct)
            queue_idle_noise($urandom_range(0, 3));
    endtask

    task automatic fill_random(input int target);
        words_planned = 0;
        while (words_planned < target)
            queue_random_transfer();
    endtask

    // Hold until every word is taken and every bus step is back, then settle
    task automatic drain();
        do
            @(posedge i_clk);
        while (words_taken != words_issued || bus_steps_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_timeout_limit(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_now = value;
        gen_limit = int'(value);
    endtask

    task automatic flag_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
        if (mismatches < 40)
            $display("MISMATCH result word %0d %s: got %0h, expected %0h",
                     results_checked, field, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Command side: offer queued words, predict each accepted one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        t_item   w;
        t_result step;
        int      gap_left;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                words_taken++;
                if (advance_sequence(word_on_bus, step))
                    bus_steps_due.push_back(step);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (command_words.size() > 0) begin
                    w = command_words.pop_front();
                    word_on_bus <= w;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= w.command;
                    s_axis_tdata <= {1'b0, w.write_byte, w.received_byte, w.status_code,
                                     w.transfer_length, w.register_index, w.device_address};
                    if (sender_idles && $urandom_range(0, 99) < 25)
                        gap_left = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: throttle tready, check each word against the oldest step
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_steps
        t_result want;
        int      hold_left;
        bit      long_stall_taken;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            long_stall_taken = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (bus_steps_due.size() == 0) begin
                    flag_mismatch("unexpected word, bus_action", 16'(m_axis_tuser), 16'd0);
                end else begin
                    want = bus_steps_due.pop_front();
                    if (m_axis_tuser !== want.bus_action)
                        flag_mismatch("bus_action", 16'(m_axis_tuser), 16'(want.bus_action));
                    if (m_axis_tdata[7:0] !== want.transmit_byte)
                        flag_mismatch("transmit_byte", 16'(m_axis_tdata[7:0]),
                                      16'(want.transmit_byte));
                    if (m_axis_tdata[8] !== want.read_valid)
                        flag_mismatch("read_valid", 16'(m_axis_tdata[8]), 16'(want.read_valid));
                    if (m_axis_tdata[16:9] !== want.read_byte)
                        flag_mismatch("read_byte", 16'(m_axis_tdata[16:9]), 16'(want.read_byte));
                    if (m_axis_tdata[32:17] !== want.read_index)
                        flag_mismatch("read_index", m_axis_tdata[32:17], want.read_index);
                    if (m_axis_tdata[33] !== want.data_request)
                        flag_mismatch("data_request", 16'(m_axis_tdata[33]),
                                      16'(want.data_request));
                    if (m_axis_tdata[34] !== want.done_res)
                        flag_mismatch("done_res", 16'(m_axis_tdata[34]), 16'(want.done_res));
                    if (m_axis_tdata[35] !== want.error)
                        flag_mismatch("error", 16'(m_axis_tdata[35]), 16'(want.error));
                    if (m_axis_tlast !== want.last)
                        flag_mismatch("tlast", 16'(m_axis_tlast), 16'(want.last));
                end
                results_checked++;
            end
            // Hold off once for a long stretch so the block backs up
            if (long_stall_armed && !long_stall_taken && bus_steps_due.size() > 0) begin
                long_stall_taken = 1'b1;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (receiver_stalls && $urandom_range(0, 99) < 20)
                    hold_left = pick_gap();
            end
        end
    end

    // Drop the run when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run plan
    // ------------------------------------------------------------------
    initial begin : run_plan
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed at the reset limit: field extremes, short reads and writes
        noise_pct = 0;
        queue_read(7'h7F, 8'hFF, 16'd0, -1);
        queue_write(7'h00, 8'h00, 16'd0, -1);
        queue_write(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 16'd1, -1);
        queue_read(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 16'd2, -1);
        for (int k = 0; k < 4; k++)
            queue_idle_noise(k);
        // Every tick short of the limit survives, the full count times out
        queue_begin(1'b1, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 16'd3);
        queue_ticks(gen_limit);

        noise_pct = 30;
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        fill_random(40);
        drain();

        // Tightest limit: every awaited step can time out
        set_timeout_limit(16'd1);
        queue_read(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 16'hFFFF, 0);
        queue_write(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 16'hFFFF, 3);
        fill_random(50);
        drain();

        // Widest limit, back-to-back words against one long receiver stall
        set_timeout_limit(16'hFFFF);
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        long_stall_armed = 1'b1;
        fill_random(50);
        queue_read(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 16'd4, -1);
        drain();

        // Small random limit with frequent aborts
        set_timeout_limit(16'($urandom_range(2, 16)));
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        queue_begin(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 16'd2);
        queue_ticks(gen_limit - 1);
        queue_status(ST_START);
        queue_ticks(gen_limit);
        fill_random(60);
        drain();

        $display("Ran %0d command words: %0d transfers begun, %0d timed out, %0d results checked",
                 words_taken, transfers_begun, timeouts_seen, results_checked);
        $display("Timeout limits exercised: reset value, 1, 65535 and a small random value");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
